// ===== src/mains_voltage_supervisor_assert.svh =====
// ----------------------------------------------------------------------------
// Mains voltage supervisor assertion macros
// Shared macros for the concurrent checks of the supervisor.
// ----------------------------------------------------------------------------
`ifndef MAINS_VOLTAGE_SUPERVISOR_ASSERT_SVH
`define MAINS_VOLTAGE_SUPERVISOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("supervisor check failed");

// The consequent must hold in the cycle after the antecedent.
`define MVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("supervisor check failed");

`endif

// ===== src/mvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Mains voltage supervisor package
// Register indexes, reset values and the shared debounce step.
// ----------------------------------------------------------------------------
package mvs_pkg;

    localparam int VOLT_W   = 9;
    localparam int PAIR_W   = 18;
    localparam int CNT_W    = 8;
    localparam int LONG_W   = 14;
    localparam int DELAY_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MAINS_115      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_PAIR_MAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_PAIR_ALT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UP_PAIR        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_DEBOUNCE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DEBOUNCE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAYS   = 3'd7;

    localparam logic [VOLT_W-1:0]  RST_LOW_THRESHOLD  = 9'd184;
    localparam logic [PAIR_W-1:0]  RST_DOWN_PAIR_MAIN = 18'd124134;
    localparam logic [PAIR_W-1:0]  RST_DOWN_PAIR_ALT  = 18'd64120;
    localparam logic [PAIR_W-1:0]  RST_UP_PAIR        = 18'd105178;
    localparam logic [CNT_W-1:0]   RST_LOW_DEBOUNCE   = 8'd10;
    localparam logic [CNT_W-1:0]   RST_STEP_DEBOUNCE  = 8'd10;
    localparam logic [DELAY_W-1:0] RST_START_DELAYS   = 16'd1822;

    typedef struct packed {
        logic             flag;
        logic [CNT_W-1:0] count;
    } dbnc_t;

    // One second of a debounced flag: the counter runs while the condition
    // that would toggle the flag holds, and the flag toggles at the limit.
    function automatic dbnc_t debounce(input logic flag, input logic [CNT_W-1:0] count,
                                       input logic set_c, input logic clr_c,
                                       input logic [CNT_W-1:0] limit);
        dbnc_t            r;
        logic [CNT_W-1:0] c;
        logic             cond;
        cond    = flag ? clr_c : set_c;
        c       = count + 8'd1;
        r.flag  = flag;
        r.count = '0;
        if (cond)
        begin
            if (c >= limit)
            begin
                r.flag = ~flag;
            end
            else
            begin
                r.count = c;
            end
        end
        return r;
    endfunction

endpackage

// ===== src/mains_voltage_supervisor.sv =====
// A result beat is registered and appears in the cycle after its input beat is
// accepted. Throughput: one input beat per cycle unless m_tready stalls; the
// single output register lets a new beat in during the same cycle in which the waiting result is taken.
// Reset: rst_n clears all flags, counters and timers and loads the register
// reset values; the block is ready straight after reset.
// ----------------------------------------------------------------------------
// Mains voltage supervisor
// Debounces undervoltage, buck and boost relay flags from a per-second
// voltage reading and times the long and short start-up delays.
// ----------------------------------------------------------------------------
`include "mains_voltage_supervisor_assert.svh"

module mains_voltage_supervisor
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [mvs_pkg::CFG_IDX_W-1:0]         cfg_addr,
    input  logic [mvs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vac[8:0], power_failed[9], arm_long[10], arm_short[11], zero pad
    input  logic [mvs_pkg::IN_DATA_W-1:0]         s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // undervoltage[0], buck_relay[1], boost_relay[2], long_delay_done[3],
    // short_delay_done[4], zero pad
    output logic [mvs_pkg::OUT_DATA_W-1:0]        m_tdata
);

    logic                           mains_115_reg;
    logic [mvs_pkg::VOLT_W-1:0]     low_threshold_reg;
    logic [mvs_pkg::PAIR_W-1:0]     down_pair_main_reg;
    logic [mvs_pkg::PAIR_W-1:0]     down_pair_alt_reg;
    logic [mvs_pkg::PAIR_W-1:0]     up_pair_reg;
    logic [mvs_pkg::CNT_W-1:0]      low_debounce_reg;
    logic [mvs_pkg::CNT_W-1:0]      step_debounce_reg;
    logic [mvs_pkg::DELAY_W-1:0]    start_delays_reg;

    logic                           low_flag_reg, low_flag_next;
    logic [mvs_pkg::CNT_W-1:0]      low_count_reg, low_count_next;
    logic                           buck_flag_reg, buck_flag_next;
    logic [mvs_pkg::CNT_W-1:0]      buck_count_reg, buck_count_next;
    logic                           boost_flag_reg, boost_flag_next;
    logic [mvs_pkg::CNT_W-1:0]      boost_count_reg, boost_count_next;
    logic                           long_running_reg, long_running_next;
    logic [mvs_pkg::LONG_W-1:0]     long_count_reg, long_count_next;
    logic                           long_done_reg, long_done_next;
    logic                           short_running_reg, short_running_next;
    logic [mvs_pkg::CNT_W-1:0]      short_count_reg, short_count_next;
    logic                           short_done_reg, short_done_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [mvs_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                           accept;
    logic [mvs_pkg::VOLT_W-1:0]     vac;
    logic                           power_failed;
    logic                           arm_long;
    logic                           arm_short;

    assign s_tready     = !m_tvalid_reg || m_tready;
    assign accept       = s_tvalid && s_tready;
    assign vac          = s_tdata[8:0];
    assign power_failed = s_tdata[9];
    assign arm_long     = s_tdata[10];
    assign arm_short    = s_tdata[11];
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mains_115_reg      <= 1'b0;
            low_threshold_reg  <= mvs_pkg::RST_LOW_THRESHOLD;
            down_pair_main_reg <= mvs_pkg::RST_DOWN_PAIR_MAIN;
            down_pair_alt_reg  <= mvs_pkg::RST_DOWN_PAIR_ALT;
            up_pair_reg        <= mvs_pkg::RST_UP_PAIR;
            low_debounce_reg   <= mvs_pkg::RST_LOW_DEBOUNCE;
            step_debounce_reg  <= mvs_pkg::RST_STEP_DEBOUNCE;
            start_delays_reg   <= mvs_pkg::RST_START_DELAYS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                mvs_pkg::REG_MAINS_115:      mains_115_reg      <= cfg_wdata[0];
                mvs_pkg::REG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_wdata[8:0];
                mvs_pkg::REG_DOWN_PAIR_MAIN: down_pair_main_reg <= cfg_wdata;
                mvs_pkg::REG_DOWN_PAIR_ALT:  down_pair_alt_reg  <= cfg_wdata;
                mvs_pkg::REG_UP_PAIR:        up_pair_reg        <= cfg_wdata;
                mvs_pkg::REG_LOW_DEBOUNCE:   low_debounce_reg   <= cfg_wdata[7:0];
                mvs_pkg::REG_STEP_DEBOUNCE:  step_debounce_reg  <= cfg_wdata[7:0];
                mvs_pkg::REG_START_DELAYS:   start_delays_reg   <= cfg_wdata[15:0];
                default:                     mains_115_reg      <= mains_115_reg;
            endcase
        end
    end

    always_comb
    begin
        logic [mvs_pkg::PAIR_W-1:0]   buck_pair;
        logic [mvs_pkg::VOLT_W-1:0]   buck_on, buck_off, boost_on, boost_off;
        logic                         buck_en, boost_en;
        mvs_pkg::dbnc_t               low_r, buck_r, boost_r;
        logic [7:0]                   minutes;
        logic [mvs_pkg::LONG_W-1:0]   long_target, long_c;
        logic [mvs_pkg::CNT_W-1:0]    short_c;

        low_r = mvs_pkg::debounce(low_flag_reg, low_count_reg, vac <= low_threshold_reg,
                                  vac > low_threshold_reg, low_debounce_reg);
        if (power_failed)
        begin
            low_r = '0;
        end

        // Relay rules use the done flags held before this second.
        buck_en   = !mains_115_reg || long_done_reg || short_done_reg;
        boost_en  = !mains_115_reg || (!long_done_reg && short_done_reg);
        buck_pair = (mains_115_reg && !long_done_reg) ? down_pair_alt_reg
                                                      : down_pair_main_reg;
        buck_on   = buck_pair[17:9];
        buck_off  = buck_pair[8:0];
        boost_on  = up_pair_reg[17:9];
        boost_off = up_pair_reg[8:0];

        buck_r = mvs_pkg::debounce(buck_flag_reg, buck_count_reg, vac >= buck_on,
                                   vac <= buck_off, step_debounce_reg);
        if (!buck_en)
        begin
            buck_r = {buck_flag_reg, buck_count_reg};
        end
        boost_r = mvs_pkg::debounce(boost_flag_reg, boost_count_reg, vac <= boost_on,
                                    vac >= boost_off, step_debounce_reg);
        if (!boost_en)
        begin
            boost_r = {boost_flag_reg, boost_count_reg};
        end

        // Minutes times sixty as a shift and subtract; at most 15300.
        minutes     = start_delays_reg[15:8];
        long_target = {minutes, 6'b0} - {4'b0, minutes, 2'b0};

        long_running_next = long_running_reg || arm_long;
        long_count_next   = long_count_reg;
        long_done_next    = long_done_reg;
        long_c            = long_count_reg + 14'd1;
        if (long_running_next)
        begin
            if (long_c >= long_target)
            begin
                long_count_next   = '0;
                long_running_next = 1'b0;
                long_done_next    = 1'b1;
            end
            else
            begin
                long_count_next = long_c;
            end
        end

        short_running_next = short_running_reg || arm_short;
        short_count_next   = short_count_reg;
        short_done_next    = short_done_reg;
        short_c            = short_count_reg + 8'd1;
        if (short_running_next)
        begin
            if (short_c >= start_delays_reg[7:0])
            begin
                short_count_next   = '0;
                short_running_next = 1'b0;
                short_done_next    = 1'b1;
            end
            else
            begin
                short_count_next = short_c;
            end
        end

        low_flag_next    = low_r.flag;
        low_count_next   = low_r.count;
        buck_flag_next   = buck_r.flag;
        buck_count_next  = buck_r.count;
        boost_flag_next  = boost_r.flag;
        boost_count_next = boost_r.count;

        m_tdata_next  = {3'b0, short_done_next, long_done_next, boost_r.flag,
                         buck_r.flag, low_r.flag};
        m_tvalid_next = accept || (m_tvalid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_flag_reg      <= 1'b0;
            low_count_reg     <= '0;
            buck_flag_reg     <= 1'b0;
            buck_count_reg    <= '0;
            boost_flag_reg    <= 1'b0;
            boost_count_reg   <= '0;
            long_running_reg  <= 1'b0;
            long_count_reg    <= '0;
            long_done_reg     <= 1'b0;
            short_running_reg <= 1'b0;
            short_count_reg   <= '0;
            short_done_reg    <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                low_flag_reg      <= low_flag_next;
                low_count_reg     <= low_count_next;
                buck_flag_reg     <= buck_flag_next;
                buck_count_reg    <= buck_count_next;
                boost_flag_reg    <= boost_flag_next;
                boost_count_reg   <= boost_count_next;
                long_running_reg  <= long_running_next;
                long_count_reg    <= long_count_next;
                long_done_reg     <= long_done_next;
                short_running_reg <= short_running_next;
                short_count_reg   <= short_count_next;
                short_done_reg    <= short_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    `MVS_ASSERT_NEXT(long_done_sticky, long_done_reg, long_done_reg)
    `MVS_ASSERT_NEXT(short_done_sticky, short_done_reg, short_done_reg)
    `MVS_ASSERT_SAME(long_idle_count_zero, !long_running_reg, long_count_reg == '0)
    `MVS_ASSERT_NEXT(accept_gives_result, accept, m_tvalid_reg)
    `MVS_ASSERT_NEXT(power_fail_clears_low, accept && power_failed,
                     !m_tdata_reg[0] && low_count_reg == '0)

endmodule

// ===== sim/mains_voltage_supervisor_test.sv =====
// ----------------------------------------------------------------------------
// Mains voltage supervisor testbench
// Drives per-second voltage readings into the supervisor through its stream
// input. A built-in predictor tracks the debounced flags and the start-up
// timers, and each output beat is checked against it. The run moves through
// 220 V rules, 115 V rules before any delay, after the short delay and after
// the long delay, with directed extremes and randomised register settings.
// ----------------------------------------------------------------------------
module mains_voltage_supervisor_test;

    localparam int SECONDS_PER_MIN = 60;

    typedef struct {
        logic                         mains_115;
        logic [mvs_pkg::VOLT_W-1:0]   low_threshold;
        logic [mvs_pkg::PAIR_W-1:0]   down_pair_main;
        logic [mvs_pkg::PAIR_W-1:0]   down_pair_alt;
        logic [mvs_pkg::PAIR_W-1:0]   up_pair;
        logic [mvs_pkg::CNT_W-1:0]    low_debounce;
        logic [mvs_pkg::CNT_W-1:0]    step_debounce;
        logic [mvs_pkg::DELAY_W-1:0]  start_delays;
    } supervisor_cfg_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [mvs_pkg::CFG_IDX_W-1:0]   cfg_addr = mvs_pkg::REG_MAINS_115;
    logic [mvs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // vac[8:0], power_failed[9], arm_long[10], arm_short[11], zero pad
    logic [mvs_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // undervoltage[0], buck_relay[1], boost_relay[2], long_delay_done[3],
    // short_delay_done[4], zero pad
    logic [mvs_pkg::OUT_DATA_W-1:0]  m_tdata;

    supervisor_cfg_t        cfg_now;
    bit                     gaps_on = 1'b1;
    int                     mismatches = 0;
    logic [4:0]             expected_flags[$];
    logic [4:0]             want;
    string                  flag_names[5] = '{"undervoltage", "buck_relay", "boost_relay",
                                              "long_delay_done", "short_delay_done"};

    // Predicted state of the supervisor
    logic                          uv_flag = 1'b0;
    logic [mvs_pkg::CNT_W-1:0]     uv_cnt = '0;
    logic                          buck_on = 1'b0;
    logic [mvs_pkg::CNT_W-1:0]     buck_cnt = '0;
    logic                          boost_on = 1'b0;
    logic [mvs_pkg::CNT_W-1:0]     boost_cnt = '0;
    logic                          long_run = 1'b0;
    logic [mvs_pkg::LONG_W-1:0]    long_cnt = '0;
    logic                          long_fin = 1'b0;
    logic                          short_run = 1'b0;
    logic [mvs_pkg::CNT_W-1:0]     short_cnt = '0;
    logic                          short_fin = 1'b0;

    mains_voltage_supervisor uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // The counter runs while the condition that would flip the flag holds.
    task automatic hysteresis(inout logic flag, inout logic [mvs_pkg::CNT_W-1:0] cnt,
                              input logic set_c, input logic clr_c,
                              input logic [mvs_pkg::CNT_W-1:0] limit);
        logic [mvs_pkg::CNT_W-1:0] nxt;
        nxt = cnt + 1'b1;
        if (flag ? clr_c : set_c)
        begin
            if (nxt >= limit)
            begin
                nxt = '0;
                flag = ~flag;
            end
            cnt = nxt;
        end
        else
        begin
            cnt = '0;
        end
    endtask

    task automatic step_buck(input logic [mvs_pkg::VOLT_W-1:0] vac,
                             input logic [mvs_pkg::PAIR_W-1:0] pair);
        hysteresis(buck_on, buck_cnt, vac >= pair[17:9], vac <= pair[8:0],
                   cfg_now.step_debounce);
    endtask

    task automatic step_boost(input logic [mvs_pkg::VOLT_W-1:0] vac);
        hysteresis(boost_on, boost_cnt, vac <= cfg_now.up_pair[17:9],
                   vac >= cfg_now.up_pair[8:0], cfg_now.step_debounce);
    endtask

    task automatic predict_second(input logic [mvs_pkg::VOLT_W-1:0] vac, input logic pf,
                                  input logic arm_l, input logic arm_s);
        logic                        long_was;
        logic                        short_was;
        logic [mvs_pkg::LONG_W-1:0]  lnext;
        logic [mvs_pkg::CNT_W-1:0]   snext;
        long_was  = long_fin;
        short_was = short_fin;
        if (pf)
        begin
            uv_flag = 1'b0;
            uv_cnt  = '0;
        end
        else
        begin
            hysteresis(uv_flag, uv_cnt, vac <= cfg_now.low_threshold,
                       vac > cfg_now.low_threshold, cfg_now.low_debounce);
        end
        // Relay rules look at the delay flags as they stood before this second.
        if (!cfg_now.mains_115)
        begin
            step_buck(vac, cfg_now.down_pair_main);
            step_boost(vac);
        end
        else if (long_was)
        begin
            step_buck(vac, cfg_now.down_pair_main);
        end
        else if (short_was)
        begin
            step_buck(vac, cfg_now.down_pair_alt);
            step_boost(vac);
        end
        if (arm_l)
        begin
            long_run = 1'b1;
        end
        if (long_run)
        begin
            lnext = long_cnt + 1'b1;
            if (int'(lnext) >= int'(cfg_now.start_delays[15:8]) * SECONDS_PER_MIN)
            begin
                lnext    = '0;
                long_run = 1'b0;
                long_fin = 1'b1;
            end
            long_cnt = lnext;
        end
        if (arm_s)
        begin
            short_run = 1'b1;
        end
        if (short_run)
        begin
            snext = short_cnt + 1'b1;
            if (snext >= cfg_now.start_delays[7:0])
            begin
                snext     = '0;
                short_run = 1'b0;
                short_fin = 1'b1;
            end
            short_cnt = snext;
        end
        expected_flags.push_back({short_fin, long_fin, boost_on, buck_on, uv_flag});
    endtask

    task automatic poke(input logic [mvs_pkg::CFG_IDX_W-1:0] idx,
                        input logic [mvs_pkg::CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic write_regs(input supervisor_cfg_t c);
        cfg_wr_en <= 1'b1;
        poke(mvs_pkg::REG_MAINS_115, mvs_pkg::CFG_DATA_W'(c.mains_115));
        poke(mvs_pkg::REG_LOW_THRESHOLD, mvs_pkg::CFG_DATA_W'(c.low_threshold));
        poke(mvs_pkg::REG_DOWN_PAIR_MAIN, c.down_pair_main);
        poke(mvs_pkg::REG_DOWN_PAIR_ALT, c.down_pair_alt);
        poke(mvs_pkg::REG_UP_PAIR, c.up_pair);
        poke(mvs_pkg::REG_LOW_DEBOUNCE, mvs_pkg::CFG_DATA_W'(c.low_debounce));
        poke(mvs_pkg::REG_STEP_DEBOUNCE, mvs_pkg::CFG_DATA_W'(c.step_debounce));
        poke(mvs_pkg::REG_START_DELAYS, mvs_pkg::CFG_DATA_W'(c.start_delays));
        cfg_wr_en <= 1'b0;
        cfg_now = c;
    endtask

    function automatic supervisor_cfg_t random_settings(
        input logic mains, input logic [mvs_pkg::DELAY_W-1:0] delays);
        supervisor_cfg_t c;
        c.mains_115      = mains;
        c.low_threshold  = mvs_pkg::VOLT_W'($urandom);
        c.down_pair_main = mvs_pkg::PAIR_W'($urandom);
        c.down_pair_alt  = mvs_pkg::PAIR_W'($urandom);
        c.up_pair        = mvs_pkg::PAIR_W'($urandom);
        c.low_debounce   = ($urandom_range(0, 7) == 0)
                         ? mvs_pkg::CNT_W'($urandom_range(6, 40))
                         : mvs_pkg::CNT_W'($urandom_range(1, 5));
        c.step_debounce  = ($urandom_range(0, 7) == 0)
                         ? mvs_pkg::CNT_W'($urandom_range(6, 40))
                         : mvs_pkg::CNT_W'($urandom_range(1, 5));
        c.start_delays   = delays;
        return c;
    endfunction

    // A voltage close to one of the current thresholds, or anywhere at all.
    function automatic logic [mvs_pkg::VOLT_W-1:0] pick_level();
        int base;
        int v;
        case ($urandom_range(0, 8))
            0: base = int'(cfg_now.low_threshold);
            1: base = int'(cfg_now.down_pair_main[17:9]);
            2: base = int'(cfg_now.down_pair_main[8:0]);
            3: base = int'(cfg_now.down_pair_alt[17:9]);
            4: base = int'(cfg_now.down_pair_alt[8:0]);
            5: base = int'(cfg_now.up_pair[17:9]);
            6: base = int'(cfg_now.up_pair[8:0]);
            default: base = int'($urandom_range(0, 511));
        endcase
        v = base + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 511)
        begin
            v = 511;
        end
        return v[mvs_pkg::VOLT_W-1:0];
    endfunction

    task automatic send_second(input logic [mvs_pkg::VOLT_W-1:0] vac, input logic pf,
                               input logic arm_l, input logic arm_s);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, arm_s, arm_l, pf, vac};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_second(vac, pf, arm_l, arm_s);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    // Runs of a steady reading of random length, up to two past the larger debounce limit,
    // broken now and then by a stray reading or a power failure.
    task automatic random_seconds(input int n, input bit long_ok, input bit short_ok);
        int                          sent;
        int                          cap;
        logic [mvs_pkg::VOLT_W-1:0]  lvl;
        sent = 0;
        while (sent < n)
        begin
            lvl = pick_level();
            cap = int'(cfg_now.low_debounce) > int'(cfg_now.step_debounce)
                ? int'(cfg_now.low_debounce) + 2 : int'(cfg_now.step_debounce) + 2;
            repeat ($urandom_range(1, cap))
            begin
                send_second(($urandom_range(0, 9) == 0) ? mvs_pkg::VOLT_W'($urandom) : lvl,
                            $urandom_range(0, 31) == 0,
                            long_ok && $urandom_range(0, 19) == 0,
                            short_ok && $urandom_range(0, 19) == 0);
                sent++;
            end
        end
    endtask

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_flags.size() == 0)
            begin
                report($sformatf("result beat %b with none expected", m_tdata[4:0]));
            end
            else
            begin
                want = expected_flags.pop_front();
                for (int i = 0; i < 5; i++)
                begin
                    if (m_tdata[i] !== want[i])
                    begin
                        report($sformatf("%s expected %b, got %b",
                                         flag_names[i], want[i], m_tdata[i]));
                    end
                end
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (gaps_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    task automatic test_reset_state();
        send_second(9'd0, 1'b0, 1'b0, 1'b0);
        send_second(9'd511, 1'b0, 1'b0, 1'b0);
        send_second(9'd184, 1'b1, 1'b0, 1'b0);
        send_second(9'd185, 1'b0, 1'b0, 1'b0);
        send_second(9'd242, 1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_instant_toggle();
        supervisor_cfg_t c;
        c = cfg_now;
        c.low_threshold  = 9'd0;
        c.down_pair_main = {9'd511, 9'd0};
        c.up_pair        = {9'd0, 9'd511};
        c.low_debounce   = 8'd1;
        c.step_debounce  = 8'd1;
        write_regs(c);
        send_second(9'd0, 1'b0, 1'b0, 1'b0);
        send_second(9'd0, 1'b1, 1'b0, 1'b0);
        send_second(9'd511, 1'b0, 1'b0, 1'b0);
        send_second(9'd1, 1'b0, 1'b0, 1'b0);
        send_second(9'd0, 1'b0, 1'b0, 1'b0);
        wait_for_results();
        c.low_threshold = 9'd511;
        write_regs(c);
        send_second(9'd511, 1'b0, 1'b0, 1'b0);
        send_second(9'd511, 1'b1, 1'b0, 1'b0);
        send_second(9'd256, 1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_slow_debounce();
        supervisor_cfg_t c;
        c = cfg_now;
        c.low_threshold  = mvs_pkg::RST_LOW_THRESHOLD;
        c.down_pair_main = mvs_pkg::RST_DOWN_PAIR_MAIN;
        c.up_pair        = mvs_pkg::RST_UP_PAIR;
        c.low_debounce   = 8'd255;
        c.step_debounce  = 8'd255;
        write_regs(c);
        repeat (256) send_second(9'd100, 1'b0, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_220_random();
        repeat (2)
        begin
            write_regs(random_settings(1'b0, mvs_pkg::RST_START_DELAYS));
            random_seconds(80, 1'b0, 1'b0);
            wait_for_results();
        end
    endtask

    task automatic test_115_before_delays();
        write_regs(random_settings(1'b1, mvs_pkg::RST_START_DELAYS));
        random_seconds(60, 1'b0, 1'b0);
        wait_for_results();
    endtask

    task automatic test_short_delay();
        write_regs(random_settings(1'b1, 16'h0028));
        send_second(pick_level(), 1'b0, 1'b0, 1'b1);
        random_seconds(60, 1'b0, 1'b1);
        wait_for_results();
    endtask

    task automatic test_115_short_rules();
        for (int k = 0; k < 3; k++)
        begin
            write_regs(random_settings(k != 1, cfg_now.start_delays));
            random_seconds(60, 1'b0, 1'b1);
            wait_for_results();
        end
    endtask

    task automatic test_long_delay();
        write_regs(random_settings(1'b1, 16'h0228));
        send_second(pick_level(), 1'b0, 1'b1, 1'b0);
        random_seconds(2 * SECONDS_PER_MIN + 10, 1'b1, 1'b1);
        wait_for_results();
    endtask

    task automatic test_long_rules();
        supervisor_cfg_t c;
        repeat (2)
        begin
            write_regs(random_settings(1'b1, 16'hFFFF));
            random_seconds(40, 1'b1, 1'b1);
            wait_for_results();
        end
        write_regs(random_settings(1'b1, 16'h0000));
        random_seconds(40, 1'b1, 1'b1);
        wait_for_results();
        c = random_settings(1'b0, 16'h0000);
        c.down_pair_main = 18'h3FFFF;
        c.down_pair_alt  = 18'h3FFFF;
        c.up_pair        = 18'h00000;
        c.step_debounce  = 8'd1;
        write_regs(c);
        send_second(9'd511, 1'b0, 1'b1, 1'b1);
        send_second(9'd0, 1'b0, 1'b0, 1'b0);
        send_second(9'd511, 1'b1, 1'b0, 1'b0);
        random_seconds(40, 1'b1, 1'b1);
        wait_for_results();
    endtask

    initial
    begin
        cfg_now.mains_115      = 1'b0;
        cfg_now.low_threshold  = mvs_pkg::RST_LOW_THRESHOLD;
        cfg_now.down_pair_main = mvs_pkg::RST_DOWN_PAIR_MAIN;
        cfg_now.down_pair_alt  = mvs_pkg::RST_DOWN_PAIR_ALT;
        cfg_now.up_pair        = mvs_pkg::RST_UP_PAIR;
        cfg_now.low_debounce   = mvs_pkg::RST_LOW_DEBOUNCE;
        cfg_now.step_debounce  = mvs_pkg::RST_STEP_DEBOUNCE;
        cfg_now.start_delays   = mvs_pkg::RST_START_DELAYS;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_instant_toggle();
        test_slow_debounce();
        test_220_random();
        test_115_before_delays();
        test_short_delay();
        test_115_short_rules();
        test_long_delay();
        gaps_on = 1'b0;
        test_long_rules();
        repeat (4) @(posedge clk);
        mismatches += expected_flags.size();
        if (mismatches == 0)
        begin
            $display("PASS mains_voltage_supervisor");
        end
        else
        begin
            $display("FAIL mains_voltage_supervisor");
        end
        $finish;
    end

    initial
    begin
        #2_400_000;
        $display("FAIL mains_voltage_supervisor");
        $finish;
    end

endmodule
